// ===== hdl/hsl_to_rgb_converter_assert.svh =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_assert.svh
// assertion macros shared by the colour converter
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HSL2RGB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// antecedent implies consequent after the delay given by dly
`define HSL2RGB_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
    else $error("assertion failed: label");

`endif

// ===== hdl/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// types and constants of the hsl to rgb colour converter
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  localparam int FRAC_BITS = 10;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int FRAC_W    = FRAC_BITS + 1;       // fraction field width
  localparam int LVL_W     = 2 * FRAC_BITS + 1;   // levels scaled by ONE*ONE
  localparam int NUM_W     = 2 * FRAC_BITS + 6;   // up to 60*ONE*ONE
  localparam int PROD_W    = NUM_W + 5;           // 17 times the numerator
  localparam int RES_SHIFT = 2 * FRAC_BITS + 2;   // 255/60 = 17/4

  localparam int HUE_W     = 16;
  localparam int U_W       = HUE_W + 1;
  localparam int DEG_MOD   = 360;
  localparam int HUE_BIAS  = DEG_MOD * 92;        // makes any hue non-negative
  localparam int RED_STEPS = 8;                   // quotient bits of the hue reduction
  localparam int RED_SPLIT = 4;                   // steps done in the first stage
  localparam int REM1_W    = 13;                  // holds values below 360 << RED_SPLIT
  localparam int DEG_W     = 9;                   // holds 0..360
  localparam int K_W       = 6;                   // ramp weight 0..60

  localparam int RAMP_RISE_END   = 60;
  localparam int RAMP_FALL_START = 180;
  localparam int RAMP_FALL_END   = 240;
  localparam int OFFSET_DEG      = 120;

  typedef struct packed {
    logic signed [HUE_W-1:0]  hue_degrees;
    logic        [FRAC_W-1:0] saturation;
    logic        [FRAC_W-1:0] lightness;
  } hsl2rgb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsl2rgb_out_t;

  // reduced hue and the two levels handed to the channel ramps
  typedef struct packed {
    logic [DEG_W-1:0] hue;
    logic [LVL_W-1:0] lo;
    logic [LVL_W-1:0] diff;
  } hsl2rgb_lvl_t;

endpackage

// ===== hdl/hsl2rgb_front.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_front
// two stages: hue reduced modulo 360, upper and lower levels
// ----------------------------------------------------------------------------
module hsl2rgb_front (
  input  logic                      clk_i,
  input  hsl2rgb_pkg::hsl2rgb_in_t  hsl_i,
  output hsl2rgb_pkg::hsl2rgb_lvl_t lvl_o
);

  localparam int LW = hsl2rgb_pkg::LVL_W;
  localparam int FW = hsl2rgb_pkg::FRAC_W;
  localparam int UW = hsl2rgb_pkg::U_W;
  localparam int RW = hsl2rgb_pkg::REM1_W;

  logic [FW-1:0]   s_d, s_q, l_d, l_q;
  logic [LW-1:0]   ls_d, ls_q;
  logic [RW-1:0]   rem_d, rem_q;
  logic [UW-1:0]   u;
  logic [2*FW-1:0] prod;

  // stage one: clamp, l*s, upper quotient bits of the hue
  always_comb begin
    s_d  = (hsl_i.saturation > FW'(hsl2rgb_pkg::ONE)) ? FW'(hsl2rgb_pkg::ONE)
                                                      : hsl_i.saturation;
    l_d  = (hsl_i.lightness > FW'(hsl2rgb_pkg::ONE)) ? FW'(hsl2rgb_pkg::ONE)
                                                     : hsl_i.lightness;
    prod = (2*FW)'(s_d) * (2*FW)'(l_d);
    ls_d = prod[LW-1:0];
    u    = {hsl_i.hue_degrees[hsl2rgb_pkg::HUE_W-1], hsl_i.hue_degrees}
           + UW'(hsl2rgb_pkg::HUE_BIAS);
    for (int k = hsl2rgb_pkg::RED_STEPS - 1; k >= hsl2rgb_pkg::RED_SPLIT; k--) begin
      if (u >= UW'(hsl2rgb_pkg::DEG_MOD << k)) begin
        u = u - UW'(hsl2rgb_pkg::DEG_MOD << k);
      end
    end
    rem_d = u[RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    l_q   <= l_d;
    ls_q  <= ls_d;
    rem_q <= rem_d;
  end

  logic [RW-1:0] r2;
  logic [LW:0]   l_sc, s_sc, hi, lo;
  hsl2rgb_pkg::hsl2rgb_lvl_t lvl_d, lvl_q;

  // stage two: lower quotient bits, levels
  always_comb begin
    r2 = rem_q;
    for (int k = hsl2rgb_pkg::RED_SPLIT - 1; k >= 0; k--) begin
      if (r2 >= RW'(hsl2rgb_pkg::DEG_MOD << k)) begin
        r2 = r2 - RW'(hsl2rgb_pkg::DEG_MOD << k);
      end
    end
    l_sc = (LW+1)'(l_q) << hsl2rgb_pkg::FRAC_BITS;
    s_sc = (LW+1)'(s_q) << hsl2rgb_pkg::FRAC_BITS;
    // half lightness and above take l + s - l*s, below it l + l*s
    if (l_q < FW'(hsl2rgb_pkg::ONE / 2)) begin
      hi = l_sc + (LW+1)'(ls_q);
    end else begin
      hi = l_sc + s_sc - (LW+1)'(ls_q);
    end
    lo         = (l_sc << 1) - hi;
    lvl_d.hue  = r2[hsl2rgb_pkg::DEG_W-1:0];
    lvl_d.lo   = lo[LW-1:0];
    lvl_d.diff = LW'(hi - lo);
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
  end

  assign lvl_o = lvl_q;

endmodule

// ===== hdl/hsl2rgb_channel.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_channel
// three stage ramp of one colour channel at a given hue position
// ----------------------------------------------------------------------------
module hsl2rgb_channel (
  input  logic                                  clk_i,
  input  logic [hsl2rgb_pkg::DEG_W-1:0]         pos_i,
  input  logic [hsl2rgb_pkg::LVL_W-1:0]         lo_i,
  input  logic [hsl2rgb_pkg::LVL_W-1:0]         diff_i,
  output logic [7:0]                            value_o
);

  localparam int DW = hsl2rgb_pkg::DEG_W;
  localparam int KW = hsl2rgb_pkg::K_W;
  localparam int NW = hsl2rgb_pkg::NUM_W;
  localparam int LW = hsl2rgb_pkg::LVL_W;
  localparam int PW = hsl2rgb_pkg::PROD_W;

  logic [KW-1:0] k_d, k_q;
  logic [NW-1:0] base_d, base_q;
  logic [LW-1:0] diff_q;
  logic [DW-1:0] fall;

  // ramp weight: rising, flat top, falling, flat bottom
  always_comb begin
    fall = DW'(hsl2rgb_pkg::RAMP_FALL_END) - pos_i;
    priority if (pos_i < DW'(hsl2rgb_pkg::RAMP_RISE_END)) begin
      k_d = pos_i[KW-1:0];
    end else if (pos_i < DW'(hsl2rgb_pkg::RAMP_FALL_START)) begin
      k_d = KW'(hsl2rgb_pkg::RAMP_RISE_END);
    end else if (pos_i < DW'(hsl2rgb_pkg::RAMP_FALL_END)) begin
      k_d = fall[KW-1:0];
    end else begin
      k_d = '0;
    end
    // 60 * lo
    base_d = (NW'(lo_i) << 6) - (NW'(lo_i) << 2);
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    base_q <= base_d;
    diff_q <= diff_i;
  end

  logic [NW+1:0] num_d;
  logic [NW-1:0] num_q;

  always_comb begin
    num_d = (NW+2)'(base_q) + (NW+2)'(diff_q) * (NW+2)'(k_q);
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d[NW-1:0];
  end

  logic [PW-1:0] prod;
  logic [8:0]    res;
  logic [7:0]    value_d, value_q;

  // 255/60 = 17/4, so the floor is (17 * num) >> RES_SHIFT, clamped to 255
  always_comb begin
    prod    = (PW'(num_q) << 4) + PW'(num_q);
    res     = prod[hsl2rgb_pkg::RES_SHIFT +: 9];
    value_d = res[8] ? 8'hFF : res[7:0];
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== hdl/hsl_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// converts one hsl pixel to 8-bit rgb per clock cycle
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  command   in         start_i / busy_o       hsl_i   (hue, saturation, lightness)
//  result    out        result_valid_o strobe  rgb_o   (red, green, blue)
//
//  one item per cycle; each result passes two front stages (hue reduction,
//  levels) and three channel stages (weight, multiply-add, scale). busy_o
//  stays low, the pipeline never holds.
//  reset clears only the valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  hsl2rgb_pkg::hsl2rgb_in_t  hsl_i,
  output logic                      result_valid_o,
  output hsl2rgb_pkg::hsl2rgb_out_t rgb_o
);

  localparam int DW      = hsl2rgb_pkg::DEG_W;
  localparam int LATENCY = 5;

  logic [LATENCY-1:0]        vld_d, vld_q;
  hsl2rgb_pkg::hsl2rgb_lvl_t lvl;
  logic [DW-1:0]             pos_r, pos_b, pr_raw;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[LATENCY-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  hsl2rgb_front u_front (
    .clk_i (clk_i),
    .hsl_i (hsl_i),
    .lvl_o (lvl)
  );

  // red a third of a turn ahead, blue a third behind, wrapped
  always_comb begin
    pr_raw = lvl.hue + DW'(hsl2rgb_pkg::OFFSET_DEG);
    pos_r  = (pr_raw > DW'(hsl2rgb_pkg::DEG_MOD)) ? pr_raw - DW'(hsl2rgb_pkg::DEG_MOD)
                                                  : pr_raw;
    pos_b  = (lvl.hue >= DW'(hsl2rgb_pkg::OFFSET_DEG))
             ? lvl.hue - DW'(hsl2rgb_pkg::OFFSET_DEG)
             : lvl.hue + DW'(hsl2rgb_pkg::DEG_MOD - hsl2rgb_pkg::OFFSET_DEG);
  end

  hsl2rgb_channel u_red (
    .clk_i   (clk_i),
    .pos_i   (pos_r),
    .lo_i    (lvl.lo),
    .diff_i  (lvl.diff),
    .value_o (rgb_o.red)
  );

  hsl2rgb_channel u_green (
    .clk_i   (clk_i),
    .pos_i   (lvl.hue),
    .lo_i    (lvl.lo),
    .diff_i  (lvl.diff),
    .value_o (rgb_o.green)
  );

  hsl2rgb_channel u_blue (
    .clk_i   (clk_i),
    .pos_i   (pos_b),
    .lo_i    (lvl.lo),
    .diff_i  (lvl.diff),
    .value_o (rgb_o.blue)
  );

  assign result_valid_o = vld_q[LATENCY-1];

`include "hsl_to_rgb_converter_assert.svh"

  `HSL2RGB_ASSERT_DELAY(a_start_to_result, clk_i, rst_ni, start_i && !busy_o, 5, result_valid_o)
  `HSL2RGB_ASSERT_IMPLIES(a_result_had_start, clk_i, rst_ni, result_valid_o, $past(start_i, 5))
  `HSL2RGB_ASSERT_IMPLIES(a_grey_when_unsaturated, clk_i, rst_ni, result_valid_o && ($past(hsl_i.saturation, 5) == '0), (rgb_o.red == rgb_o.green) && (rgb_o.green == rgb_o.blue))
  `HSL2RGB_ASSERT_IMPLIES(a_black_when_dark, clk_i, rst_ni, result_valid_o && ($past(hsl_i.lightness, 5) == '0), rgb_o == '0)

endmodule
